/* rtl/sct_pkg.sv */
// Package for the sparse chunked tile store: word types, register indexes,
// controller states and the control and status structs between modules.
// No dependencies.
`default_nettype none

package sct_pkg;

	// Configuration register indexes
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 7;

	localparam logic [CFG_INDEX_W-1:0] REG_CHUNK_SHIFT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CHUNKS_X    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CHUNKS_Y    = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_CHUNKS_Z    = 2'd3;

	localparam logic [2:0] RST_CHUNK_SHIFT = 3'd4;
	localparam logic [6:0] RST_CHUNKS      = 7'd4;

	// Opcodes and status codes
	localparam logic OP_READ    = 1'b0;
	localparam logic OP_WRITE   = 1'b1;
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_OOR = 1'b1;

	// Tile values that count as empty
	localparam logic [7:0] EMPTY_A = 8'd1;
	localparam logic [7:0] EMPTY_B = 8'd3;
	localparam logic [7:0] EMPTY_C = 8'd4;

	typedef struct packed {
		logic        opcode;
		logic [15:0] tile_x;
		logic [15:0] tile_y;
		logic [5:0]  tile_z;
		logic [7:0]  new_value;
	} req_word_t;

	typedef struct packed {
		logic [7:0] tile_value;
		logic       is_empty;
		logic       status;
	} rsp_word_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SPLIT,
		ST_SLOT,
		ST_LOOKUP,
		ST_UPDATE,
		ST_REPLY
	} state_t;

	typedef struct packed {
		logic clearing;
		logic req_ready;
		logic cap_item;
		logic cap_split;
		logic cap_slot;
		logic lookup;
		logic update;
		logic load_out;
	} ctrl_t;

	typedef struct packed {
		logic req_valid;
		logic out_busy;
		logic clear_last;
		logic range_ok;
	} stat_t;

	function automatic logic empty_flag(input logic [7:0] v);
		return (v == EMPTY_A) || (v == EMPTY_B) || (v == EMPTY_C);
	endfunction

endpackage

`default_nettype wire

/* rtl/sct_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
`default_nettype none

module sct_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire                                   clk,
	input  wire                                   we,
	input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire [WIDTH-1:0]                       wdata,
	input  wire                                   re,
	input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/sct_ctrl.sv */
// Sequencer for the tile store: clearing pass after reset, then one item at
// a time through split, slot, lookup, update (in range only) and reply. Depends on sct_pkg.
`default_nettype none

module sct_ctrl
	import sct_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire stat_t stat,
	output ctrl_t      ctrl
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (stat.clear_last) state_d = ST_IDLE;
			ST_IDLE:   if (stat.req_valid) state_d = ST_SPLIT;
			ST_SPLIT:  state_d = ST_SLOT;
			ST_SLOT:   state_d = ST_LOOKUP;
			ST_LOOKUP: state_d = stat.range_ok ? ST_UPDATE : ST_REPLY;
			ST_UPDATE: state_d = ST_REPLY;
			ST_REPLY:  if (!stat.out_busy) state_d = ST_IDLE;
			default:   state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		ctrl = '0;
		unique case (state_q)
			ST_CLEAR:  ctrl.clearing = 1'b1;
			ST_IDLE: begin
				ctrl.req_ready = 1'b1;
				ctrl.cap_item  = stat.req_valid;
			end
			ST_SPLIT:  ctrl.cap_split = 1'b1;
			ST_SLOT:   ctrl.cap_slot = 1'b1;
			ST_LOOKUP: ctrl.lookup = 1'b1;
			ST_UPDATE: ctrl.update = 1'b1;
			ST_REPLY:  ctrl.load_out = !stat.out_busy;
			default:   ctrl = '0;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/sparse_chunked_tile_store_core.sv */
// Top level of the sparse chunked tile store: configuration registers,
// address datapath, chunk-present bits, tile memory and output register.
// Depends on sct_pkg, sct_ram and sct_ctrl.
`default_nettype none

//  channel   | signals                          | direction | handshake
//  ----------+----------------------------------+-----------+-------------------
//  request   | req_valid, req_ready, req        | in        | valid/ready
//  response  | rsp_valid, rsp_ready, rsp        | out       | valid/ready
//  config    | cfg_we, cfg_index, cfg_data      | in        | write enable only
//
//  An in-range word passes through idle, split, slot, lookup, update and reply
//  before the next one can be accepted; an out-of-range word skips the update.
//  The response is valid once the reply state has loaded the output register.
//  The steps are set by the two chained multiplies of the slot index (layer,
//  then slot) and the read-then-write round trip through the tile memory.
//  After reset all CHUNK_SLOTS * 4**MAX_CHUNK_SHIFT entries (16384 at defaults)
//  of the tile memory are swept once, one entry a cycle; no request is taken
//  until it ends. Configuration writes are taken at any time.
//  The result waits in an output register; a stalled response holds the
//  controller in the reply state and no request is taken meanwhile.

module sparse_chunked_tile_store_core
	import sct_pkg::*;
#(
	parameter int unsigned MAX_CHUNK_SHIFT = 4,
	parameter int unsigned CHUNK_SLOTS     = 64,
	parameter int unsigned VALUE_BITS      = 8
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   req_valid,
	output logic                  req_ready,
	input  wire req_word_t        req,
	output logic                  rsp_valid,
	input  wire                   rsp_ready,
	output rsp_word_t             rsp,
	input  wire                   cfg_we,
	input  wire [CFG_INDEX_W-1:0] cfg_index,
	input  wire [CFG_DATA_W-1:0]  cfg_data
);

	// Each slot owns a fixed region of 4**MAX_CHUNK_SHIFT tiles.
	localparam int unsigned OFF_BITS    = 2 * MAX_CHUNK_SHIFT;
	localparam int unsigned STORE_DEPTH = CHUNK_SLOTS * (1 << OFF_BITS);
	localparam int unsigned ADDR_W      = STORE_DEPTH > 1 ? $clog2(STORE_DEPTH) : 1;
	localparam int unsigned SLOT_W      = CHUNK_SLOTS > 1 ? $clog2(CHUNK_SLOTS) : 1;
	localparam int unsigned MEM_W       = VALUE_BITS + 1;

	// Configuration registers
	logic [2:0] shift_q;
	logic [6:0] chunks_x_q, chunks_y_q, chunks_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q    <= RST_CHUNK_SHIFT;
			chunks_x_q <= RST_CHUNKS;
			chunks_y_q <= RST_CHUNKS;
			chunks_z_q <= RST_CHUNKS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CHUNK_SHIFT: shift_q    <= cfg_data[2:0];
				REG_CHUNKS_X:    chunks_x_q <= cfg_data;
				REG_CHUNKS_Y:    chunks_y_q <= cfg_data;
				REG_CHUNKS_Z:    chunks_z_q <= cfg_data;
				default:         shift_q    <= shift_q;
			endcase
		end
	end

	ctrl_t ctrl;
	stat_t stat;

	// Control state
	logic              out_valid_q;
	logic [ADDR_W-1:0] clr_q;
	logic [CHUNK_SLOTS-1:0] present_q;

	// Payload registers
	req_word_t         item_q;
	rsp_word_t         res_q, out_q;
	logic              rng_ok_q, slot_ok_q, hit_q;
	logic [6:0]        cx_q;
	logic [12:0]       layer_q;
	logic [ADDR_W-1:0] off_q, addr_q;
	logic [SLOT_W-1:0] slot_q;

	// Split: clamp the shift, take chunk coordinates and in-chunk offsets apart, first (layer) multiply
	logic [2:0]  sh;
	logic [15:0] off_mask, cx, cy, ox, oy;
	logic [31:0] off_full;
	logic [12:0] layer;

	always_comb begin
		sh       = (shift_q > 3'(MAX_CHUNK_SHIFT)) ? 3'(MAX_CHUNK_SHIFT) : shift_q;
		off_mask = (16'd1 << sh) - 16'd1;
		cx       = item_q.tile_x >> sh;
		cy       = item_q.tile_y >> sh;
		ox       = item_q.tile_x & off_mask;
		oy       = item_q.tile_y & off_mask;
		off_full = ({16'd0, oy} << sh) | {16'd0, ox};
		layer    = 13'(item_q.tile_z) * 13'(chunks_y_q) + 13'(cy[6:0]);
	end

	// Slot: second multiply, then the slot-count bound
	logic [19:0] slot_full;
	assign slot_full = 20'(layer_q) * 20'(chunks_x_q) + 20'(cx_q);

	// Lookup address
	logic [ADDR_W-1:0] addr;
	assign addr = (ADDR_W'(slot_q) << OFF_BITS) | off_q;

	// Memory word: {written, value}
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr;
	logic [MEM_W-1:0]  mem_wdata, mem_rdata;

	// Value width conversions through zero-extended staging words
	logic [VALUE_BITS+7:0] nv_ext, rd_ext;
	logic [VALUE_BITS-1:0] nv_v, rd_v, val_v;
	logic [7:0]            val8;

	always_comb begin
		nv_ext = {VALUE_BITS'(0), item_q.new_value};
		nv_v   = nv_ext[VALUE_BITS-1:0];
		if (item_q.opcode == OP_WRITE) begin
			rd_v = nv_v;
		end else if (!hit_q) begin
			rd_v = '0;
		end else if (mem_rdata[MEM_W-1]) begin
			rd_v = mem_rdata[VALUE_BITS-1:0];
		end else begin
			rd_v = VALUE_BITS'(1);
		end
		val_v  = rd_v;
		rd_ext = {8'd0, val_v};
		val8   = rd_ext[7:0];
	end

	always_comb begin
		mem_re    = ctrl.lookup && slot_ok_q;
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = {1'b1, nv_v};
		if (ctrl.clearing) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (ctrl.update && item_q.opcode == OP_WRITE) begin
			mem_we = 1'b1;
		end
	end

	sct_ram #(
		.WIDTH(MEM_W),
		.DEPTH(STORE_DEPTH)
	) u_tiles (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(addr),
		.rdata(mem_rdata)
	);

	always_comb begin
		stat.req_valid  = req_valid;
		stat.out_busy   = out_valid_q && !rsp_ready;
		stat.clear_last = clr_q == ADDR_W'(STORE_DEPTH - 1);
		stat.range_ok   = slot_ok_q;
	end

	sct_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.stat  (stat),
		.ctrl  (ctrl)
	);

	// Control registers: sweep counter, chunk-present bits, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			present_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.clearing) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			// Allocate on the first write; a fresh region reads 1 because the
			// sweep left every written bit clear and nothing else touches it.
			if (ctrl.update && item_q.opcode == OP_WRITE) begin
				present_q[slot_q] <= 1'b1;
			end
			if (ctrl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers, advanced one step per controller state
	always_ff @(posedge clk) begin
		if (ctrl.cap_item) begin
			item_q <= req;
		end
		if (ctrl.cap_split) begin
			rng_ok_q <= (cx < 16'(chunks_x_q)) && (cy < 16'(chunks_y_q))
				&& ({1'b0, item_q.tile_z} < chunks_z_q);
			cx_q     <= cx[6:0];
			layer_q  <= layer;
			off_q    <= ADDR_W'(off_full);
		end
		if (ctrl.cap_slot) begin
			slot_ok_q <= rng_ok_q && (slot_full < 20'(CHUNK_SLOTS));
			slot_q    <= slot_full[SLOT_W-1:0];
		end
		if (ctrl.lookup) begin
			addr_q <= addr;
			hit_q  <= present_q[slot_q];
			// Out of range: zero value, drop any write
			res_q  <= '{tile_value: 8'd0, is_empty: 1'b0, status: STATUS_OOR};
		end
		if (ctrl.update) begin
			res_q <= '{tile_value: val8, is_empty: empty_flag(val8), status: STATUS_OK};
		end
		if (ctrl.load_out) begin
			out_q <= res_q;
		end
	end

	assign req_ready = ctrl.req_ready;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

`ifndef SYNTHESIS
	a_no_read_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.clearing |-> !mem_re && !req_ready)
		else $error("tile memory read or request taken during sweep");

	a_load_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load_out |-> (!out_valid_q || rsp_ready))
		else $error("output register overwritten while held");

	a_write_allocates: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.update && item_q.opcode == OP_WRITE) |=> present_q[$past(slot_q)])
		else $error("write did not allocate its chunk");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == STATUS_OOR) |-> (rsp.tile_value == 8'd0 && !rsp.is_empty))
		else $error("out-of-range result carries a value");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && !ctrl.clearing) |-> slot_ok_q)
		else $error("memory written for an out-of-range word");
`endif

endmodule

`default_nettype wire

/* verif/sparse_chunked_tile_store_core_tb.sv */
// Testbench for sparse_chunked_tile_store_core: directed words, random read/write mixes
// and a backpressure run over several chunk layouts, checked word by word against a
// tile-map predictor. Depends on sct_pkg and the core RTL only.
`timescale 1ns / 100ps

module sparse_chunked_tile_store_core_tb;
	import sct_pkg::*;

	localparam int unsigned MAX_SHIFT    = 4;
	localparam int unsigned SLOT_COUNT   = 64;
	localparam int unsigned REGION_TILES = 1 << (2 * MAX_SHIFT);
	localparam int unsigned STORE_DEPTH  = SLOT_COUNT * REGION_TILES;
	// The limit covers the sweep after reset and several times the slowest mix.
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned SETTLE       = 12;
	localparam int unsigned HOLD_CYCLES  = 300;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	req_word_t             req       = '0;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	rsp_word_t             rsp;
	logic                  cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	// Predictor copy of the layout registers, written when the block takes them
	logic [2:0] lay_shift = RST_CHUNK_SHIFT;
	logic [6:0] lay_x     = RST_CHUNKS;
	logic [6:0] lay_y     = RST_CHUNKS;
	logic [6:0] lay_z     = RST_CHUNKS;

	// Predictor copy of the map contents
	bit         chunk_alloc [SLOT_COUNT];
	bit         tile_set    [STORE_DEPTH];
	logic [7:0] tile_mem    [STORE_DEPTH];

	rsp_word_t   pending_tiles[$];	// expected words, oldest first
	req_word_t   recent_words[$];	// coordinates to revisit
	int unsigned mismatch_cnt  = 0;
	int unsigned cycle_cnt     = 0;
	int unsigned send_idle_pct = 0;
	int unsigned rsp_stall_pct = 0;
	logic        hold_active   = 1'b0;
	event        hold_off_go;

	sparse_chunked_tile_store_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// Apply one read or write to the predicted map and return the word it yields.
	function automatic rsp_word_t tile_map_step(req_word_t w);
		rsp_word_t   r;
		int unsigned sh, cx, cy, ox, oy, slot, addr, i;
		r  = '0;
		r.status = STATUS_OK;
		sh = (lay_shift > MAX_SHIFT) ? MAX_SHIFT : lay_shift;
		cx = w.tile_x >> sh;
		cy = w.tile_y >> sh;
		ox = w.tile_x & ((1 << sh) - 1);
		oy = w.tile_y & ((1 << sh) - 1);
		if (cx >= lay_x || cy >= lay_y || w.tile_z >= lay_z) begin
			r.status = STATUS_OOR;
			return r;
		end
		slot = w.tile_z * lay_y * lay_x + cy * lay_x + cx;
		if (slot >= SLOT_COUNT) begin
			r.status = STATUS_OOR;
			return r;
		end
		addr = slot * REGION_TILES + ((oy << sh) | ox);
		if (w.opcode == OP_WRITE) begin
			// A fresh chunk reads 1 everywhere until a tile is stored
			if (!chunk_alloc[slot]) begin
				chunk_alloc[slot] = 1'b1;
				for (i = 0; i < REGION_TILES; i++)
					tile_set[slot * REGION_TILES + i] = 1'b0;
			end
			tile_mem[addr] = w.new_value;
			tile_set[addr] = 1'b1;
			r.tile_value   = w.new_value;
		end else if (!chunk_alloc[slot]) begin
			r.tile_value = 8'd0;
		end else begin
			r.tile_value = tile_set[addr] ? tile_mem[addr] : EMPTY_A;
		end
		r.is_empty = (r.tile_value == EMPTY_A) || (r.tile_value == EMPTY_B) ||
			(r.tile_value == EMPTY_C);
		return r;
	endfunction

	function automatic req_word_t tile_op(logic op, int unsigned x, int unsigned y,
			int unsigned z, int unsigned v);
		req_word_t w;
		w.opcode    = op;
		w.tile_x    = 16'(x);
		w.tile_y    = 16'(y);
		w.tile_z    = 6'(z);
		w.new_value = 8'(v);
		return w;
	endfunction

	// Build a random word: mostly in-range coordinates of the current layout,
	// often revisiting recent tiles, with some raw noise over the full fields.
	function automatic req_word_t random_word();
		req_word_t   w, old;
		int unsigned sh, span, s, cx, cy, cz;
		w.opcode    = ($urandom_range(1) == 1) ? OP_WRITE : OP_READ;
		w.new_value = ($urandom_range(3) == 0) ? 8'($urandom_range(5)) : 8'($urandom);
		span = lay_x * lay_y * lay_z;
		if ($urandom_range(9) == 0 || span == 0) begin
			w.tile_x = 16'($urandom);
			w.tile_y = 16'($urandom);
			w.tile_z = 6'($urandom);
			return w;
		end
		if (recent_words.size() != 0 && $urandom_range(99) < 40) begin
			old = recent_words[$urandom_range(recent_words.size() - 1)];
			w.tile_x = old.tile_x;
			w.tile_y = old.tile_y;
			w.tile_z = old.tile_z;
			return w;
		end
		sh = (lay_shift > MAX_SHIFT) ? MAX_SHIFT : lay_shift;
		if (span > SLOT_COUNT)
			span = SLOT_COUNT;
		s  = $urandom_range(span - 1);
		cx = s % lay_x;
		cy = (s / lay_x) % lay_y;
		cz = s / (lay_x * lay_y);
		w.tile_x = 16'((cx << sh) | $urandom_range((1 << sh) - 1));
		w.tile_y = 16'((cy << sh) | $urandom_range((1 << sh) - 1));
		w.tile_z = 6'(cz);
		recent_words.push_back(w);
		if (recent_words.size() > 16)
			void'(recent_words.pop_front());
		return w;
	endfunction

	// Offer one word after a random gap; hold valid and payload until taken.
	// Valid is left high on return so back-to-back words keep it asserted.
	task automatic send_word(req_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= w;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		pending_tiles.push_back(tile_map_step(w));
	endtask

	task automatic run_random(int unsigned count);
		repeat (count) send_word(random_word());
	endtask

	// Drop valid and wait until every expected word has come back.
	task automatic wait_idle();
		req_valid <= 1'b0;
		while (pending_tiles.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write all four layout registers, one per cycle; only call while idle.
	task automatic set_layout(int unsigned sh, int unsigned nx, int unsigned ny,
			int unsigned nz);
		logic [CFG_INDEX_W-1:0] idx [4];
		logic [CFG_DATA_W-1:0]  val [4];
		idx[0] = REG_CHUNK_SHIFT;
		idx[1] = REG_CHUNKS_X;
		idx[2] = REG_CHUNKS_Y;
		idx[3] = REG_CHUNKS_Z;
		// Spare upper bits on the shift write must be ignored
		val[0] = {4'($urandom), 3'(sh)};
		val[1] = 7'(nx);
		val[2] = 7'(ny);
		val[3] = 7'(nz);
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			case (idx[i])
				REG_CHUNK_SHIFT: lay_shift = val[i][2:0];
				REG_CHUNKS_X:    lay_x     = val[i];
				REG_CHUNKS_Y:    lay_y     = val[i];
				REG_CHUNKS_Z:    lay_z     = val[i];
				default: ;
			endcase
		end
		cfg_we <= 1'b0;
	endtask

	// Reset layout, edge of 16 tiles: absent chunks, allocation, empty flags,
	// value extremes, and out-of-range x, y and layer coordinates.
	task automatic test_directed();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		send_word(tile_op(OP_READ,  0, 0, 0, 8'hFF));	// absent chunk reads 0
		send_word(tile_op(OP_WRITE, 5, 7, 0, 8'hAB));	// allocates chunk 0
		send_word(tile_op(OP_READ,  5, 7, 0, 0));
		send_word(tile_op(OP_READ,  6, 7, 0, 0));		// untouched tile reads 1
		send_word(tile_op(OP_WRITE, 0, 0, 0, EMPTY_B));
		send_word(tile_op(OP_WRITE, 15, 15, 0, EMPTY_C));
		send_word(tile_op(OP_READ,  15, 15, 0, 0));
		send_word(tile_op(OP_WRITE, 1, 0, 0, 8'hFF));
		send_word(tile_op(OP_READ,  1, 0, 0, 0));
		send_word(tile_op(OP_WRITE, 2, 0, 0, 8'h00));
		send_word(tile_op(OP_READ,  2, 0, 0, 0));
		send_word(tile_op(OP_READ,  63, 63, 3, 0));	// last slot, absent
		send_word(tile_op(OP_WRITE, 63, 63, 3, EMPTY_A));
		send_word(tile_op(OP_READ,  63, 63, 3, 0));
		send_word(tile_op(OP_READ,  62, 63, 3, 0));
		send_word(tile_op(OP_READ,  64, 0, 0, 0));	// x past the grid
		send_word(tile_op(OP_WRITE, 64, 0, 0, 8'h55));	// dropped
		send_word(tile_op(OP_WRITE, 0, 64, 0, 8'h55));	// y past the grid
		send_word(tile_op(OP_WRITE, 0, 0, 4, 8'h55));	// layer past the grid
		send_word(tile_op(OP_WRITE, 16'hFFFF, 16'hFFFF, 63, 8'hFF));
		send_word(tile_op(OP_READ,  16, 0, 0, 0));	// neighbor chunk still absent
		send_word(tile_op(OP_WRITE, 16, 0, 0, 8'h80));
		send_word(tile_op(OP_READ,  31, 0, 0, 0));
		wait_idle();
	endtask

	// Layout extremes; stored tiles stay put and are seen through each new layout.
	task automatic test_layout_extremes();
		send_idle_pct = 20;
		rsp_stall_pct = 20;
		// One-tile chunks in a single row of 64
		set_layout(0, 64, 1, 1);
		send_word(tile_op(OP_READ,  0, 0, 0, 0));
		send_word(tile_op(OP_WRITE, 63, 0, 0, 8'h3C));
		send_word(tile_op(OP_READ,  63, 0, 0, 0));
		send_word(tile_op(OP_READ,  64, 0, 0, 0));
		send_word(tile_op(OP_READ,  0, 1, 0, 0));
		run_random(30);
		wait_idle();
		// Shift above the maximum acts as the maximum
		set_layout(7, 1, 1, 1);
		send_word(tile_op(OP_READ,  5, 7, 0, 0));
		send_word(tile_op(OP_READ,  16, 0, 0, 0));
		send_word(tile_op(OP_WRITE, 15, 15, 0, 8'hC3));
		run_random(30);
		wait_idle();
		// Slot index past the slot count: layer 1 starts at slot 64
		set_layout(4, 8, 8, 4);
		send_word(tile_op(OP_READ,  64, 0, 0, 0));	// earlier dropped write left nothing
		send_word(tile_op(OP_WRITE, 0, 0, 1, 8'h11));
		send_word(tile_op(OP_READ,  0, 0, 1, 0));
		send_word(tile_op(OP_WRITE, 127, 127, 0, 8'h22));
		send_word(tile_op(OP_READ,  127, 127, 0, 0));
		run_random(30);
		wait_idle();
		// Largest counts: only the first 64 slots exist
		set_layout(1, 64, 64, 64);
		send_word(tile_op(OP_WRITE, 127, 1, 0, 8'h44));
		send_word(tile_op(OP_READ,  127, 1, 0, 0));
		send_word(tile_op(OP_READ,  1, 2, 0, 0));
		send_word(tile_op(OP_READ,  0, 0, 63, 0));
		run_random(30);
		wait_idle();
		// A zero count puts every coordinate out of range, writes included
		set_layout(4, 4, 0, 4);
		send_word(tile_op(OP_READ,  5, 7, 0, 0));
		send_word(tile_op(OP_WRITE, 0, 0, 0, 8'h77));
		run_random(10);
		wait_idle();
	endtask

	// Long random runs, one idling mix per layout.
	task automatic test_random_mix();
		set_layout(4, 4, 4, 4);
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		run_random(300);
		wait_idle();
		set_layout(2, 8, 8, 1);
		send_idle_pct = 87;
		rsp_stall_pct = 0;
		run_random(300);
		wait_idle();
		set_layout(0, 64, 1, 1);
		send_idle_pct = 0;
		rsp_stall_pct = 87;
		run_random(300);
		wait_idle();
		set_layout(6, 2, 2, 16);
		send_idle_pct = 13;
		rsp_stall_pct = 13;
		run_random(300);
		wait_idle();
	endtask

	// Hold the response side off while words keep coming, so the input backs up.
	task automatic test_backpressure();
		set_layout(3, 4, 4, 4);
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		-> hold_off_go;
		run_random(60);
		wait_idle();
	endtask

	// Count the hold-off in cycles; the response side stays stalled meanwhile.
	always begin
		@(hold_off_go);
		hold_active <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_active <= 1'b0;
	end

	// Drive the response ready: random stalls per phase, forced low on hold-off.
	always @(posedge clk)
		rsp_ready <= !hold_active && ($urandom_range(99) >= rsp_stall_pct);

	// Compare every accepted word with the oldest expectation, field by field.
	always @(posedge clk) begin
		rsp_word_t exp_w;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_tiles.size() == 0) begin
				mismatch_cnt++;
				$display("%0t: unexpected word, expected none, got %h", $time, rsp);
			end else begin
				exp_w = pending_tiles.pop_front();
				if (rsp.tile_value !== exp_w.tile_value) begin
					mismatch_cnt++;
					$display("%0t: tile_value expected %h, got %h", $time,
						exp_w.tile_value, rsp.tile_value);
				end
				if (rsp.is_empty !== exp_w.is_empty) begin
					mismatch_cnt++;
					$display("%0t: is_empty expected %b, got %b", $time,
						exp_w.is_empty, rsp.is_empty);
				end
				if (rsp.status !== exp_w.status) begin
					mismatch_cnt++;
					$display("%0t: status expected %b, got %b", $time,
						exp_w.status, rsp.status);
				end
			end
		end
	end

	// Stop a hung run; the limit covers the memory sweep after reset.
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("** sparse_chunked_tile_store_core: FAILED **");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_layout_extremes();
		test_random_mix();
		test_backpressure();
		wait_idle();
		if (mismatch_cnt == 0 && pending_tiles.size() == 0)
			$display("** sparse_chunked_tile_store_core: PASSED **");
		else
			$display("** sparse_chunked_tile_store_core: FAILED **");
		$finish;
	end

endmodule
